@@ rtl/lea_pkg.sv @@
// Package for the LEA block cipher: constants, types and round functions.
// Used by the front end, the engine, the top level and the testbench; depends on nothing.
`default_nettype none
package lea_pkg;

    localparam int MaxRounds = 32;
    localparam int RkAddrW   = $clog2(MaxRounds);
    localparam int RoundCntW = $clog2(MaxRounds + 1);
    localparam int QueueDepth = 2;

    typedef enum logic [2:0] {
        CFG_KEY_0_1 = 3'd0,
        CFG_KEY_2_3 = 3'd1,
        CFG_KEY_4_5 = 3'd2,
        CFG_KEY_6_7 = 3'd3,
        CFG_KEY_SIZE = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        KEY_128 = 2'd0,
        KEY_192 = 2'd1,
        KEY_256 = 2'd2
    } key_size_t;

    typedef enum logic [1:0] {
        ENG_IDLE   = 2'd0,
        ENG_EXPAND = 2'd1,
        ENG_ROUNDS = 2'd2,
        ENG_DONE   = 2'd3
    } eng_state_t;

    typedef struct packed {
        logic        decrypt;
        logic        expand;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
    } job_t;

    typedef logic [31:0] word_t;

    localparam word_t Delta [8] = '{
        32'hc3efe9db, 32'h44626b02, 32'h79e27c8a, 32'h78df30ec,
        32'h715ea49e, 32'hc785da0a, 32'he04ef22a, 32'he5c40957
    };

    function automatic word_t rotl(input word_t x, input logic [4:0] s);
        logic [63:0] d;
        d = {x, x} << s;
        return d[63:32];
    endfunction

    function automatic logic [RoundCntW-1:0] round_count(input logic [1:0] ks);
        logic [RoundCntW-1:0] nr;
        unique case (ks)
            KEY_128: nr = RoundCntW'(24);
            KEY_192: nr = RoundCntW'(28);
            default: nr = RoundCntW'(32);
        endcase
        return nr;
    endfunction

endpackage
`default_nettype wire

@@ rtl/lea_front.sv @@
// Front end of the LEA block: takes requests, marks those needing key
// expansion and queues them for the engine. Depends on lea_pkg.
`default_nettype none
module lea_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          action,
    input  wire logic [31:0]   in_word_0,
    input  wire logic [31:0]   in_word_1,
    input  wire logic [31:0]   in_word_2,
    input  wire logic [31:0]   in_word_3,
    input  wire logic          cfg_write,
    output logic               job_valid,
    input  wire logic          job_take,
    output lea_pkg::job_t      job
);
    import lea_pkg::*;

    job_t        q_reg [QueueDepth];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        stale_reg, stale_next;
    logic        push;

    assign in_stall  = (count_reg == 2'(QueueDepth));
    assign push      = in_valid && !in_stall;
    assign job_valid = (count_reg != 2'd0);
    assign job       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (job_take && job_valid);
        count_next  = count_reg + 2'(push) - 2'(job_take && job_valid);
        stale_next  = stale_reg;
        if (push)
        begin
            stale_next = 1'b0;
        end
        if (cfg_write)
        begin
            stale_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            stale_reg  <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            stale_reg  <= stale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{decrypt: action, expand: stale_reg,
                                   w0: in_word_0, w1: in_word_1,
                                   w2: in_word_2, w3: in_word_3};
        end
    end

endmodule
`default_nettype wire

@@ rtl/lea_engine.sv @@
// Back end of the LEA block: key schedule expansion into the round-key
// memory and the iterative round unit with an output register. Uses lea_pkg.
`default_nettype none
module lea_engine (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [255:0]  key,
    input  wire logic [1:0]    key_size,
    input  wire logic          job_valid,
    output logic               job_take,
    input  wire lea_pkg::job_t job,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [31:0]        out_word_0,
    output logic [31:0]        out_word_1,
    output logic [31:0]        out_word_2,
    output logic [31:0]        out_word_3
);
    import lea_pkg::*;

    logic [191:0]          rk_mem [MaxRounds];
    logic [191:0]          rk;
    eng_state_t            state_reg, state_next;
    logic [RoundCntW-1:0]  cnt_reg, cnt_next;
    logic                  dec_reg;
    word_t                 x_reg [4];
    word_t                 x_next [4];
    word_t                 t_reg [8];
    word_t                 t_next [8];
    logic [2:0]            delta6_reg;
    logic [191:0]          rk_wdata;
    logic                  rk_we;
    logic [RkAddrW-1:0]    rd_addr;
    logic [RoundCntW-1:0]  nr;
    logic                  ov_reg, ov_next;
    logic                  load_x, step_x, load_t;
    word_t                 rk_w [6];
    word_t                 d;
    logic [4:0]            ci;
    word_t                 y1, y2;

    assign nr = round_count(key_size);
    assign ci = cnt_reg[4:0];
    assign out_valid  = ov_reg;
    assign out_word_0 = x_reg[0];
    assign out_word_1 = x_reg[1];
    assign out_word_2 = x_reg[2];
    assign out_word_3 = x_reg[3];

    // One key-schedule step per cycle.
    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            t_next[j] = t_reg[j];
        end
        for (int j = 0; j < 6; j++)
        begin
            rk_w[j] = '0;
        end
        d = Delta[0];
        unique case (key_size)
            KEY_128:
            begin
                d = Delta[{1'b0, ci[1:0]}];
                for (int j = 0; j < 4; j++)
                begin
                    t_next[j] = rotl(t_reg[j] + rotl(d, ci + 5'(j)),
                                     (j == 0) ? 5'd1 : (j == 1) ? 5'd3 :
                                     (j == 2) ? 5'd6 : 5'd11);
                end
                rk_w[0] = t_next[0]; rk_w[1] = t_next[1]; rk_w[2] = t_next[2];
                rk_w[3] = t_next[1]; rk_w[4] = t_next[3]; rk_w[5] = t_next[1];
            end
            KEY_192:
            begin
                d = Delta[delta6_reg];
                for (int j = 0; j < 6; j++)
                begin
                    t_next[j] = rotl(t_reg[j] + rotl(d, ci + 5'(j)),
                                     (j == 0) ? 5'd1 : (j == 1) ? 5'd3 :
                                     (j == 2) ? 5'd6 : (j == 3) ? 5'd11 :
                                     (j == 4) ? 5'd13 : 5'd17);
                    rk_w[j] = t_next[j];
                end
            end
            default:
            begin
                d = Delta[ci[2:0]];
                for (int j = 0; j < 6; j++)
                begin
                    logic [2:0] k;
                    k = 3'(ci * 3'd6) + 3'(j);
                    t_next[k] = rotl(t_reg[k] + rotl(d, ci + 5'(j)),
                                     (j == 0) ? 5'd1 : (j == 1) ? 5'd3 :
                                     (j == 2) ? 5'd6 : (j == 3) ? 5'd11 :
                                     (j == 4) ? 5'd13 : 5'd17);
                    rk_w[j] = t_next[k];
                end
            end
        endcase
        rk_wdata = {rk_w[5], rk_w[4], rk_w[3], rk_w[2], rk_w[1], rk_w[0]};
    end

    // One cipher round per cycle using the registered round key.
    always_comb
    begin
        if (!dec_reg)
        begin
            x_next[0] = rotl((x_reg[0] ^ rk[31:0]) + (x_reg[1] ^ rk[63:32]), 5'd9);
            x_next[1] = rotl((x_reg[1] ^ rk[95:64]) + (x_reg[2] ^ rk[127:96]), 5'd27);
            x_next[2] = rotl((x_reg[2] ^ rk[159:128]) + (x_reg[3] ^ rk[191:160]),
                             5'd29);
            x_next[3] = x_reg[0];
            y1 = '0;
            y2 = '0;
        end
        else
        begin
            y1 = (rotl(x_reg[0], 5'd23) - (x_reg[3] ^ rk[31:0])) ^ rk[63:32];
            y2 = (rotl(x_reg[1], 5'd5) - (y1 ^ rk[95:64])) ^ rk[127:96];
            x_next[0] = x_reg[3];
            x_next[1] = y1;
            x_next[2] = y2;
            x_next[3] = (rotl(x_reg[2], 5'd3) - (y2 ^ rk[159:128])) ^ rk[191:160];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ov_next    = ov_reg && out_stall;
        job_take   = 1'b0;
        load_x     = 1'b0;
        step_x     = 1'b0;
        load_t     = 1'b0;
        rk_we      = 1'b0;
        rd_addr    = '0;
        unique case (state_reg)
            ENG_IDLE:
            begin
                if (job_valid && !ov_next)
                begin
                    job_take = 1'b1;
                    load_x   = 1'b1;
                    load_t   = 1'b1;
                    cnt_next = '0;
                    state_next = job.expand ? ENG_EXPAND : ENG_ROUNDS;
                    rd_addr  = job.decrypt ? RkAddrW'(nr - 1'b1) : '0;
                end
            end
            ENG_EXPAND:
            begin
                rk_we    = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_next == nr)
                begin
                    cnt_next   = '0;
                    state_next = ENG_ROUNDS;
                    rd_addr    = dec_reg ? RkAddrW'(nr - 1'b1) : '0;
                end
            end
            ENG_ROUNDS:
            begin
                step_x   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                rd_addr  = dec_reg ? RkAddrW'(nr - 1'b1 - cnt_next)
                                   : RkAddrW'(cnt_next);
                if (cnt_next == nr)
                begin
                    state_next = ENG_DONE;
                end
            end
            default:
            begin
                ov_next    = 1'b1;
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ENG_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[cnt_reg[RkAddrW-1:0]] <= rk_wdata;
        end
        // The last round key may be read in the cycle that writes it.
        if (rk_we && (rd_addr == cnt_reg[RkAddrW-1:0]))
        begin
            rk <= rk_wdata;
        end
        else
        begin
            rk <= rk_mem[rd_addr];
        end
        if (load_x)
        begin
            dec_reg  <= job.decrypt;
            x_reg[0] <= job.w0;
            x_reg[1] <= job.w1;
            x_reg[2] <= job.w2;
            x_reg[3] <= job.w3;
        end
        else if (step_x)
        begin
            for (int j = 0; j < 4; j++)
            begin
                x_reg[j] <= x_next[j];
            end
        end
        if (load_t)
        begin
            for (int j = 0; j < 8; j++)
            begin
                t_reg[j] <= key[32*j +: 32];
            end
            delta6_reg <= 3'd0;
        end
        else if (rk_we)
        begin
            for (int j = 0; j < 8; j++)
            begin
                t_reg[j] <= t_next[j];
            end
            delta6_reg <= (delta6_reg == 3'd5) ? 3'd0 : delta6_reg + 3'd1;
        end
    end

endmodule
`default_nettype wire

@@ rtl/lea_block_cipher.sv @@
// LEA block cipher, top level: configuration registers, front queue and
// engine. Depends on lea_pkg, lea_front and lea_engine.
//
// Input requests (action, in_word_0..3) are taken when in_valid is high and
// in_stall low; results appear on out_word_0..3 with out_valid and are taken
// when out_stall is low. The key and key size are written through the cfg
// port (cfg_index, cfg_data, cfg_valid, cfg_ready); the user must write them
// only while the block is idle, which the block itself does not enforce. The
// first request after reset or after any configuration write first runs the
// key schedule, one round key per cycle, 24, 28 or 32 round keys. Each request
// then takes one round per cycle, 24, 28 or 32 rounds: the engine takes it
// from the queue, runs the rounds and then raises out_valid, and it takes no
// new request until the previous result has been taken. A two-entry queue
// sits in front of the engine, so requests are taken while the engine works.
// If the receiver stalls, the result holds in the output register and the
// engine waits. Reset empties the queue, drops any result, marks the key
// schedule as stale and clears the key and key size registers to zero.
`default_nettype none
module lea_block_cipher (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [31:0] in_word_0,
    input  wire logic [31:0] in_word_1,
    input  wire logic [31:0] in_word_2,
    input  wire logic [31:0] in_word_3,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      out_word_0,
    output logic [31:0]      out_word_1,
    output logic [31:0]      out_word_2,
    output logic [31:0]      out_word_3,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import lea_pkg::*;

    logic [255:0] key_reg;
    logic [1:0]   key_size_reg;
    logic         cfg_write;
    logic         job_valid;
    logic         job_take;
    job_t         job;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready &&
                       (cfg_index <= 3'(CFG_KEY_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg      <= '0;
            key_size_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY_0_1:  key_reg[63:0]    <= cfg_data;
                CFG_KEY_2_3:  key_reg[127:64]  <= cfg_data;
                CFG_KEY_4_5:  key_reg[191:128] <= cfg_data;
                CFG_KEY_6_7:  key_reg[255:192] <= cfg_data;
                CFG_KEY_SIZE: key_size_reg     <= cfg_data[1:0];
                default:      key_size_reg     <= key_size_reg;
            endcase
        end
    end

    lea_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .in_word_0 (in_word_0),
        .in_word_1 (in_word_1),
        .in_word_2 (in_word_2),
        .in_word_3 (in_word_3),
        .cfg_write (cfg_write),
        .job_valid (job_valid),
        .job_take  (job_take),
        .job       (job)
    );

    lea_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key_reg),
        .key_size   (key_size_reg),
        .job_valid  (job_valid),
        .job_take   (job_take),
        .job        (job),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word_0 (out_word_0),
        .out_word_1 (out_word_1),
        .out_word_2 (out_word_2),
        .out_word_3 (out_word_3)
    );

endmodule
`default_nettype wire

@@ rtl/lea_checker.sv @@
// Port-level checker for the LEA block cipher and its bind to the top level.
// Depends only on the top-level ports.
`default_nettype none
module lea_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] out_word_0,
    input wire logic        cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word_0))
        else $error("result changed while stalled");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_valid, in_stall, out_valid, cfg_ready}))
        else $error("handshake signal unknown");

endmodule

bind lea_block_cipher lea_checker u_lea_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word_0 (out_word_0),
    .cfg_ready  (cfg_ready)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for lea_block_cipher: drives blocks with random idling,
// predicts each result with a behavioural LEA model or a known answer and compares it.
// Depends on lea_pkg and the lea_block_cipher RTL.
`default_nettype none
module tb_top;
    import lea_pkg::*;

    typedef logic [31:0] w32_t;
    typedef struct {
        w32_t w0;
        w32_t w1;
        w32_t w2;
        w32_t w3;
    } block_t;
    typedef struct {
        logic   act;
        block_t blk;
        logic   has_known;
        block_t known;
    } vec_t;

    localparam logic ACT_ENC = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic action = 1'b0;
    logic [31:0] in_word_0 = '0, in_word_1 = '0, in_word_2 = '0, in_word_3 = '0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic in_stall, out_valid, cfg_ready;
    logic [31:0] out_word_0, out_word_1, out_word_2, out_word_3;

    lea_block_cipher dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .in_word_0(in_word_0), .in_word_1(in_word_1),
        .in_word_2(in_word_2), .in_word_3(in_word_3),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_word_0(out_word_0), .out_word_1(out_word_1),
        .out_word_2(out_word_2), .out_word_3(out_word_3),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the key registers and the expanded schedule.
    logic [63:0] key_reg [4];
    logic [1:0]  key_len;
    w32_t        sched [MaxRounds][6];
    bit          sched_valid;

    block_t ciphertext_q [$];
    int     errors = 0;
    int     n_sent = 0, n_recv = 0, n_enc = 0, n_dec = 0;
    bit     quiet = 1'b0;

    function automatic w32_t rol32(w32_t x, int unsigned s);
        s = s % 32;
        return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
    endfunction

    function automatic w32_t ror32(w32_t x, int unsigned s);
        return rol32(x, (32 - (s % 32)) % 32);
    endfunction

    function automatic int unsigned rounds_for(logic [1:0] ks);
        return (ks == KEY_128) ? 24 : (ks == KEY_192) ? 28 : 32;
    endfunction

    function automatic void build_schedule();
        w32_t t [8];
        w32_t d;
        int unsigned nr, k;
        int rot [6];
        nr = rounds_for(key_len);
        rot = '{1, 3, 6, 11, 13, 17};
        for (int n = 0; n < 4; n++)
        begin
            t[2*n]   = key_reg[n][31:0];
            t[2*n+1] = key_reg[n][63:32];
        end
        for (int unsigned i = 0; i < nr; i++)
        begin
            if (key_len == KEY_128)
            begin
                d = Delta[i % 4];
                for (int unsigned j = 0; j < 4; j++)
                    t[j] = rol32(t[j] + rol32(d, i + j), rot[j]);
                sched[i] = '{t[0], t[1], t[2], t[1], t[3], t[1]};
            end
            else if (key_len == KEY_192)
            begin
                d = Delta[i % 6];
                for (int unsigned j = 0; j < 6; j++)
                begin
                    t[j] = rol32(t[j] + rol32(d, i + j), rot[j]);
                    sched[i][j] = t[j];
                end
            end
            else
            begin
                d = Delta[i % 8];
                for (int unsigned j = 0; j < 6; j++)
                begin
                    k = (6 * i + j) % 8;
                    t[k] = rol32(t[k] + rol32(d, i + j), rot[j]);
                    sched[i][j] = t[k];
                end
            end
        end
        sched_valid = 1'b1;
    endfunction

    function automatic block_t lea_transform(logic act, block_t b);
        w32_t x [4];
        w32_t y [4];
        int unsigned nr;
        x = '{b.w0, b.w1, b.w2, b.w3};
        if (!sched_valid)
            build_schedule();
        nr = rounds_for(key_len);
        for (int unsigned i = 0; i < nr; i++)
        begin
            if (act == ACT_ENC)
            begin
                y[0] = rol32((x[0] ^ sched[i][0]) + (x[1] ^ sched[i][1]), 9);
                y[1] = ror32((x[1] ^ sched[i][2]) + (x[2] ^ sched[i][3]), 5);
                y[2] = ror32((x[2] ^ sched[i][4]) + (x[3] ^ sched[i][5]), 3);
                y[3] = x[0];
            end
            else
            begin
                y[0] = x[3];
                y[1] = (ror32(x[0], 9) - (y[0] ^ sched[nr-1-i][0])) ^ sched[nr-1-i][1];
                y[2] = (rol32(x[1], 5) - (y[1] ^ sched[nr-1-i][2])) ^ sched[nr-1-i][3];
                y[3] = (rol32(x[2], 3) - (y[2] ^ sched[nr-1-i][4])) ^ sched[nr-1-i][5];
            end
            x = y;
        end
        return '{x[0], x[1], x[2], x[3]};
    endfunction

    function automatic w32_t rnd_word();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic idle_gap(int pct);
        if (!quiet && $urandom_range(0, 99) < pct)
            repeat ($urandom_range(1, 7)) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_KEY_SIZE)
            key_len = value[1:0];
        else
            key_reg[2'(idx)] = value;
        sched_valid = 1'b0;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_block(vec_t v);
        idle_gap(25);
        @(negedge clk);
        in_valid  <= 1'b1;
        action    <= v.act;
        in_word_0 <= v.blk.w0;
        in_word_1 <= v.blk.w1;
        in_word_2 <= v.blk.w2;
        in_word_3 <= v.blk.w3;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (v.has_known)
            ciphertext_q.push_back(v.known);
        else
            ciphertext_q.push_back(lea_transform(v.act, v.blk));
        n_sent++;
        if (v.act == ACT_ENC)
            n_enc++;
        else
            n_dec++;
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (ciphertext_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic new_key(logic [1:0] ks, logic [63:0] k0, logic [63:0] k1,
                           logic [63:0] k2, logic [63:0] k3);
        drain();
        write_reg(CFG_KEY_0_1, k0);
        write_reg(CFG_KEY_2_3, k1);
        write_reg(CFG_KEY_4_5, k2);
        write_reg(CFG_KEY_6_7, k3);
        write_reg(CFG_KEY_SIZE, {62'd0, ks});
    endtask

    function automatic logic [63:0] rnd_key();
        case ($urandom_range(0, 7))
            0: return 64'h0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Result monitor and back-pressure generator.
    always @(posedge clk)
    begin
        block_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_recv++;
            if (ciphertext_q.size() == 0)
            begin
                $error("unexpected result %h %h %h %h",
                       out_word_0, out_word_1, out_word_2, out_word_3);
                errors++;
            end
            else
            begin
                want = ciphertext_q.pop_front();
                if (out_word_0 !== want.w0)
                begin
                    $error("out_word_0 expected %h actual %h", want.w0, out_word_0);
                    errors++;
                end
                if (out_word_1 !== want.w1)
                begin
                    $error("out_word_1 expected %h actual %h", want.w1, out_word_1);
                    errors++;
                end
                if (out_word_2 !== want.w2)
                begin
                    $error("out_word_2 expected %h actual %h", want.w2, out_word_2);
                    errors++;
                end
                if (out_word_3 !== want.w3)
                begin
                    $error("out_word_3 expected %h actual %h", want.w3, out_word_3);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int burst;
        burst = 0;
        forever
        begin
            @(negedge clk);
            if (burst > 0)
            begin
                burst--;
                out_stall <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 99) < 15)
            begin
                burst = $urandom_range(1, 7) - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        #20_000_000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        vec_t dir [$];
        vec_t v;
        block_t pt, ct;
        logic [1:0] ks;

        for (int n = 0; n < 4; n++)
            key_reg[n] = '0;
        key_len = KEY_128;
        sched_valid = 1'b0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: zero key after reset, extreme words, both actions,
        // then each key size including the undefined size code three.
        dir.push_back('{ACT_ENC, '{0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}});
        dir.push_back('{ACT_DEC, '{0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}});
        dir.push_back('{ACT_ENC, '{'1, '1, '1, '1}, 1'b0, '{0, 0, 0, 0}});
        dir.push_back('{ACT_DEC, '{'1, '1, '1, '1}, 1'b0, '{0, 0, 0, 0}});
        dir.push_back('{ACT_ENC, '{32'h1, 32'h8000_0000, 32'haaaa_aaaa, 32'h5555_5555},
                        1'b0, '{0, 0, 0, 0}});
        foreach (dir[i])
            send_block(dir[i]);

        for (int s = 0; s < 4; s++)
        begin
            new_key(s[1:0], {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
            pt = '{$urandom, $urandom, $urandom, $urandom};
            ct = lea_transform(ACT_ENC, pt);
            send_block('{ACT_ENC, pt, 1'b0, '{0, 0, 0, 0}});
            // A decrypt of the ciphertext must return the plaintext.
            send_block('{ACT_DEC, ct, 1'b1, pt});
            send_block('{ACT_DEC, '{'1, 0, '1, 0}, 1'b0, '{0, 0, 0, 0}});
        end
        new_key(KEY_256, '1, '1, '1, '1);
        send_block('{ACT_ENC, '{'1, '1, '1, '1}, 1'b0, '{0, 0, 0, 0}});
        send_block('{ACT_DEC, '{0, 0, 0, 0}, 1'b0, '{0, 0, 0, 0}});

        // Random part: key changes every 60 blocks.
        for (int i = 0; i < 900; i++)
        begin
            if (i % 60 == 0)
            begin
                ks = $urandom_range(0, 7) == 0 ? 2'd3 : 2'($urandom_range(0, 2));
                new_key(ks, rnd_key(), rnd_key(), rnd_key(), rnd_key());
            end
            if (i == 300)
                drain();
            if (i == 780)
                quiet = 1'b1;
            v.act = $urandom_range(0, 1);
            v.blk = '{rnd_word(), rnd_word(), rnd_word(), rnd_word()};
            v.has_known = 1'b0;
            v.known = '{0, 0, 0, 0};
            send_block(v);
        end

        drain();
        $display("Sent %0d blocks (%0d encrypt, %0d decrypt), received %0d results,",
                 n_sent, n_enc, n_dec, n_recv);
        $display("over all three key sizes and the size code three.");
        if (errors == 0 && ciphertext_q.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ files.f @@
rtl/lea_pkg.sv
rtl/lea_front.sv
rtl/lea_engine.sv
rtl/lea_block_cipher.sv
rtl/lea_checker.sv
sim/tb_top.sv
